// ===== src/iiea_pkg.sv =====
// ----------------------------------------------------------------------------
// iiea_pkg
// Shared types and constants for the indexed insert/erase array.
// ----------------------------------------------------------------------------
package iiea_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_ERASE  = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic [CNT_W-1:0]   index;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [CNT_W-1:0]   count;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

// ===== src/iiea_ram.sv =====
// ----------------------------------------------------------------------------
// iiea_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module iiea_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/iiea_ctrl.sv =====
// ----------------------------------------------------------------------------
// iiea_ctrl
// Command sequencer: keeps the count, runs the shift sweeps through the RAM
// and registers each result.
// ----------------------------------------------------------------------------
module iiea_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  iiea_pkg::cmd_t                cmd,
  output logic                          done,
  output iiea_pkg::rsp_t                rsp,
  output iiea_pkg::mem_wr_t             mem_wr,
  output iiea_pkg::mem_rd_t             mem_rd,
  input  logic [iiea_pkg::DATA_W-1:0]   mem_rdata
);
  import iiea_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  length, length_next;
  logic [ADDR_W-1:0] rd_addr, rd_addr_next;
  logic [ADDR_W-1:0] rd_left, rd_left_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              wr_valid, wr_valid_next;
  logic              is_ins, is_ins_next;
  logic [ADDR_W-1:0] ins_idx, ins_idx_next;
  logic [DATA_W-1:0] ins_val, ins_val_next;
  logic              done_next;
  rsp_t              rsp_next;
  logic [CNT_W-1:0]  full_cnt;

  assign full_cnt = CNT_W'(CAPACITY);
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    length_next   = length;
    rd_addr_next  = rd_addr;
    rd_left_next  = rd_left;
    wr_addr_next  = wr_addr;
    wr_valid_next = wr_valid;
    is_ins_next   = is_ins;
    ins_idx_next  = ins_idx;
    ins_val_next  = ins_val;
    done_next     = 1'b0;
    rsp_next      = rsp;
    mem_wr        = '0;
    mem_rd        = '0;
    mem_rd.addr   = rd_addr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          rsp_next.read_value = '0;
          rsp_next.status     = ST_OK;
          done_next           = 1'b1;
          unique case (cmd.action)
            ACT_APPEND: begin
              if (length == full_cnt) begin
                rsp_next.status = ST_FULL;
              end else begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = length[ADDR_W-1:0];
                mem_wr.data = cmd.value;
                length_next = length + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (length == '0) begin
                rsp_next.status = ST_RANGE;
              end else begin
                length_next = length - CNT_W'(1);
              end
            end
            ACT_INSERT: begin
              if (cmd.index > length) begin
                rsp_next.status = ST_RANGE;
              end else if (length == full_cnt) begin
                rsp_next.status = ST_FULL;
              end else if (cmd.index == length) begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = cmd.index[ADDR_W-1:0];
                mem_wr.data = cmd.value;
                length_next = length + CNT_W'(1);
              end else begin
                done_next     = 1'b0;
                state_next    = S_SHIFT;
                is_ins_next   = 1'b1;
                rd_addr_next  = ADDR_W'(length - CNT_W'(1));
                rd_left_next  = ADDR_W'(length - cmd.index);
                wr_valid_next = 1'b0;
                ins_idx_next  = cmd.index[ADDR_W-1:0];
                ins_val_next  = cmd.value;
              end
            end
            ACT_ERASE: begin
              if (cmd.index >= length) begin
                rsp_next.status = ST_RANGE;
              end else begin
                done_next     = 1'b0;
                state_next    = S_SHIFT;
                is_ins_next   = 1'b0;
                rd_addr_next  = ADDR_W'(cmd.index + CNT_W'(1));
                rd_left_next  = ADDR_W'(length - cmd.index - CNT_W'(1));
                wr_valid_next = 1'b0;
              end
            end
            ACT_READ: begin
              if (cmd.index >= length) begin
                rsp_next.status = ST_RANGE;
              end else begin
                done_next   = 1'b0;
                mem_rd.en   = 1'b1;
                mem_rd.addr = cmd.index[ADDR_W-1:0];
                state_next  = S_READ;
              end
            end
            ACT_CLEAR: begin
              length_next = '0;
            end
            default: begin
              rsp_next.status = ST_RANGE;
            end
          endcase
          rsp_next.count = length_next;
        end
      end

      S_SHIFT: begin
        if (wr_valid) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = wr_addr;
          mem_wr.data = mem_rdata;
        end
        if (rd_left != '0) begin
          mem_rd.en     = 1'b1;
          rd_addr_next  = is_ins ? rd_addr - ADDR_W'(1) : rd_addr + ADDR_W'(1);
          rd_left_next  = rd_left - ADDR_W'(1);
          wr_valid_next = 1'b1;
          wr_addr_next  = is_ins ? rd_addr + ADDR_W'(1) : rd_addr - ADDR_W'(1);
        end else begin
          wr_valid_next = 1'b0;
          if (!wr_valid) begin
            if (is_ins) begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = ins_idx;
              mem_wr.data = ins_val;
              length_next = length + CNT_W'(1);
            end else begin
              length_next = length - CNT_W'(1);
            end
            done_next           = 1'b1;
            rsp_next.read_value = '0;
            rsp_next.count      = length_next;
            rsp_next.status     = ST_OK;
            state_next          = S_IDLE;
          end
        end
      end

      S_READ: begin
        done_next           = 1'b1;
        rsp_next.read_value = mem_rdata;
        rsp_next.count      = length;
        rsp_next.status     = ST_OK;
        state_next          = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      length   <= '0;
      wr_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      length   <= length_next;
      wr_valid <= wr_valid_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
    rd_left <= rd_left_next;
    wr_addr <= wr_addr_next;
    is_ins  <= is_ins_next;
    ins_idx <= ins_idx_next;
    ins_val <= ins_val_next;
    rsp     <= rsp_next;
  end

endmodule

// ===== src/indexed_insert_erase_array_top.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_erase_array_top
// Bounded ordered list of signed 32-bit integers held in one RAM.
// ----------------------------------------------------------------------------
//  channel  | ports                 | beat taken when
//  ---------+-----------------------+-------------------------
//  command  | start, busy, cmd      | start high and busy low
//  result   | done, rsp             | done high (one cycle)
//
// Append, remove last, clear, refused commands and insert at the end give
// their result the cycle after the command beat. A read passes through the
// registered RAM read port and the read state. Insert and erase move one
// entry per cycle through the RAM. An erase of the last entry moves nothing
// but still enters the shift state. Reset empties the list at once; the
// receiver cannot stall results.
module indexed_insert_erase_array_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  iiea_pkg::cmd_t cmd,
  output logic           done,
  output iiea_pkg::rsp_t rsp
);
  import iiea_pkg::*;

  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [DATA_W-1:0] mem_rdata;

  iiea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .mem_rdata (mem_rdata)
  );

  iiea_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .re    (mem_rd.en),
    .raddr (mem_rd.addr),
    .rdata (mem_rdata)
  );

endmodule

// ===== src/iiea_checker.sv =====
// ----------------------------------------------------------------------------
// iiea_checker
// Port-level checks on the indexed insert/erase array.
// ----------------------------------------------------------------------------
module iiea_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input iiea_pkg::rsp_t rsp
);
  import iiea_pkg::*;

  // Every command beat is either answered at once or keeps the block busy.
  a_beat_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("command beat neither answered nor in progress");

  // A multi-cycle command ends with its result.
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.count <= CNT_W'(CAPACITY) && rsp.status != 2'd3))
    else $error("result count or status out of range");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.read_value == '0))
    else $error("refused command returned a nonzero value");

endmodule

bind indexed_insert_erase_array_top iiea_checker u_iiea_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the indexed insert/erase array against a mirror of the list.
// A short directed run covers the empty and boundary cases. Random phases
// then favour growing the list, shrinking it, or mixing
// all actions. Every command beat updates the mirror, and every result beat
// is compared field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module tb_top;
  import iiea_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int         RANDOM_ITEMS = 500;
  localparam int         DRAIN_CYCLES = 100;

  typedef enum {MIX_GROW, MIX_ANY, MIX_SHRINK} mix_t;

  class scoreboard_t;
    logic signed [31:0] cells [CAPACITY];
    int unsigned        fill;
    rsp_t               replies [$];
    int unsigned        mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function rsp_t list_action(cmd_t c);
      rsp_t        r;
      int unsigned idx;
      r      = '0;
      idx    = c.index;
      r.status = ST_OK;
      case (c.action)
        ACT_APPEND: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            cells[fill] = c.value;
            fill++;
          end
        end
        ACT_POP: begin
          if (fill == 0) r.status = ST_RANGE;
          else fill--;
        end
        ACT_INSERT: begin
          if (idx > fill) begin
            r.status = ST_RANGE;
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int k = fill; k > idx; k--) cells[k] = cells[k-1];
            cells[idx] = c.value;
            fill++;
          end
        end
        ACT_ERASE: begin
          if (idx >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int k = idx; k + 1 < fill; k++) cells[k] = cells[k+1];
            fill--;
          end
        end
        ACT_READ: begin
          if (idx >= fill) r.status = ST_RANGE;
          else r.read_value = cells[idx];
        end
        ACT_CLEAR: fill = 0;
        default: r.status = ST_RANGE;
      endcase
      r.count = CNT_W'(fill);
      return r;
    endfunction

    function void note_command(cmd_t c);
      replies = {replies, list_action(c)};
    endfunction

    function void report(string what, rsp_t want, rsp_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected value %0d count %0d status %0d,",
                 $realtime, what, want.read_value, want.count, want.status,
                 " got value %0d count %0d status %0d",
                 got.read_value, got.count, got.status);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t want;
      if (replies.size() == 0) begin
        report("reply without a command", '0, got);
      end else begin
        want = replies.pop_front();
        if (got.read_value !== want.read_value || got.count !== want.count ||
            got.status !== want.status)
          report("reply mismatch", want, got);
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  scoreboard_t tracker = new();

  indexed_insert_erase_array_top dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) tracker.check_reply(rsp);
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] act, int idx, logic signed [31:0] val);
    cmd_t c;
    c.action = act;
    c.index  = CNT_W'(idx);
    c.value  = val;
    return c;
  endfunction

  function automatic cmd_t noise_cmd();
    return make_cmd(3'($urandom), $urandom_range(0, 127), $urandom);
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t random_cmd(mix_t mix, int len);
    int         r;
    int         idx;
    logic [2:0] act;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 45) act = ACT_APPEND;
        else if (r < 85) act = ACT_INSERT;
        else if (r < 93) act = ACT_READ;
        else if (r < 96) act = ACT_POP;
        else if (r < 98) act = ACT_ERASE;
        else act = r[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
      end
      MIX_SHRINK: begin
        if (r < 40) act = ACT_POP;
        else if (r < 80) act = ACT_ERASE;
        else if (r < 92) act = ACT_READ;
        else if (r < 97) act = ACT_APPEND;
        else act = ACT_INSERT;
      end
      default: begin
        if (r < 18) act = ACT_APPEND;
        else if (r < 33) act = ACT_POP;
        else if (r < 51) act = ACT_INSERT;
        else if (r < 66) act = ACT_ERASE;
        else if (r < 88) act = ACT_READ;
        else if (r < 91) act = ACT_CLEAR;
        else if (r < 94) act = r[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
        else act = ACT_APPEND;
      end
    endcase
    r = $urandom_range(0, 99);
    if (act == ACT_INSERT)
      idx = (r < 85) ? $urandom_range(0, len) : $urandom_range(0, CAPACITY);
    else if (len > 0 && r < 85)
      idx = $urandom_range(0, len - 1);
    else
      idx = $urandom_range(len, CAPACITY);
    return make_cmd(act, idx, pick_value());
  endfunction

  task automatic send_command(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_command(c);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) start <= 1'b0;
    for (int i = 0; i < n; i++) begin
      cmd <= noise_cmd();
      @(posedge clk);
    end
  endtask

  task automatic issue(input cmd_t c, input bit calm);
    send_command(c);
    idle_cycles(pick_gap(calm));
  endtask

  initial begin
    int   issued;
    int   phase;
    int   span;
    bit   calm;
    mix_t mix;
    cmd_t c;
    issued = 0;
    phase  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(make_cmd(ACT_POP, 0, 0), 1'b0);
    issue(make_cmd(ACT_ERASE, 0, 0), 1'b0);
    issue(make_cmd(ACT_READ, 0, 0), 1'b0);
    issue(make_cmd(ACT_INSERT, 1, 1), 1'b0);
    issue(make_cmd(ACT_INSERT, 0, 32'sh7fffffff), 1'b0);
    issue(make_cmd(ACT_APPEND, 0, 32'sh80000000), 1'b1);
    issue(make_cmd(ACT_APPEND, 127, 0), 1'b1);
    issue(make_cmd(ACT_APPEND, 0, -32'sd1), 1'b0);
    issue(make_cmd(ACT_INSERT, 1, 32'sh55555555), 1'b0);
    issue(make_cmd(ACT_INSERT, 0, 32'shaaaaaaaa), 1'b1);
    issue(make_cmd(ACT_INSERT, 64, 7), 1'b0);
    issue(make_cmd(ACT_READ, 0, 0), 1'b1);
    issue(make_cmd(ACT_READ, 5, 0), 1'b0);
    issue(make_cmd(ACT_READ, 6, 0), 1'b0);
    issue(make_cmd(ACT_READ, 64, 0), 1'b0);
    issue(make_cmd(ACT_ERASE, 0, 0), 1'b1);
    issue(make_cmd(ACT_ERASE, 4, 0), 1'b0);
    issue(make_cmd(ACT_ERASE, 1, 0), 1'b0);
    issue(make_cmd(ACT_SPARE_LO, 0, 0), 1'b0);
    issue(make_cmd(ACT_SPARE_HI, 1, 0), 1'b0);
    issue(make_cmd(ACT_READ, 1, 0), 1'b1);
    issue(make_cmd(ACT_CLEAR, 0, 0), 1'b0);
    issue(make_cmd(ACT_READ, 0, 0), 1'b0);
    issue(make_cmd(ACT_APPEND, 0, 32'sh12345678), 1'b0);

    while (issued < RANDOM_ITEMS) begin
      case (phase % 4)
        0, 2: mix = MIX_GROW;
        1: mix = MIX_ANY;
        default: mix = MIX_SHRINK;
      endcase
      span = $urandom_range(60, 120);
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < span && issued < RANDOM_ITEMS; i++) begin
        c = random_cmd(mix, tracker.fill);
        issue(c, calm);
        if (c.action <= ACT_CLEAR) issued++;
      end
      phase++;
    end

    start <= 1'b0;
    while (tracker.replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== indexed_insert_erase_array_top.f =====
src/iiea_pkg.sv
src/iiea_ram.sv
src/iiea_ctrl.sv
src/indexed_insert_erase_array_top.sv
src/iiea_checker.sv
sim/tb_top.sv
